FILE: hw/rtl/gpio_prb_pkg.sv
// Package for the GPIO port register block: action codes, latch operation
// codes, value limits and the control struct passed from decode to the port bank.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package gpio_prb_pkg;

  // Widths of the word fields (fixed by the bus format)
  localparam int unsigned ActionW  = 3;
  localparam int unsigned PortW    = 2;
  localparam int unsigned PinW     = 5;
  localparam int unsigned ValueW   = 2;
  localparam int unsigned PadW     = 16;
  localparam int unsigned InDataW  = 32;
  localparam int unsigned OutDataW = 24;

  typedef enum logic [ActionW-1:0] {
    ACT_MODE      = 3'd0,
    ACT_OTYPE     = 3'd1,
    ACT_SPEED     = 3'd2,
    ACT_PULL      = 3'd3,
    ACT_READ_PIN  = 3'd4,
    ACT_LATCH_OP  = 3'd5,
    ACT_SET_RESET = 3'd6
  } gpio_prb_action_e;

  typedef enum logic [ValueW-1:0] {
    LATCH_CLEAR  = 2'd0,
    LATCH_SET    = 2'd1,
    LATCH_TOGGLE = 2'd2
  } gpio_prb_latch_e;

  // Highest legal setting value per action
  localparam logic [ValueW-1:0] LIM_MODE      = 2'd3;
  localparam logic [ValueW-1:0] LIM_OTYPE     = 2'd1;
  localparam logic [ValueW-1:0] LIM_SPEED     = 2'd3;
  localparam logic [ValueW-1:0] LIM_PULL      = 2'd2;
  localparam logic [ValueW-1:0] LIM_READ      = 2'd3;
  localparam logic [ValueW-1:0] LIM_LATCH_OP  = 2'd2;
  localparam logic [ValueW-1:0] LIM_SET_RESET = 2'd1;

  // Decoded item; every strobe is already qualified by ok
  typedef struct packed {
    logic ok;
    logic wr_mode;
    logic wr_otype;
    logic wr_speed;
    logic wr_pull;
    logic wr_latch;
    logic rd_pad;
  } gpio_prb_ctrl_t;

endpackage : gpio_prb_pkg

`default_nettype wire

FILE: hw/rtl/gpio_prb_decode.sv
// Item decode: port, pin and value checks, action strobes.
// Depends on gpio_prb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gpio_prb_decode
  import gpio_prb_pkg::*;
#(
  parameter int unsigned NUM_PORTS           = 3,
  parameter int unsigned PINS_PER_PORT       = 16,
  parameter int unsigned LAST_PORT_FIRST_PIN = 13
) (
  input  wire logic [ActionW-1:0] action_i,
  input  wire logic [PortW-1:0]   port_index_i,
  input  wire logic [PinW-1:0]    pin_index_i,
  input  wire logic [ValueW-1:0]  setting_value_i,
  output gpio_prb_ctrl_t          ctrl_o
);

  logic              port_ok;
  logic              pin_ok;
  logic              last_port_low;
  logic              act_ok;
  logic [ValueW-1:0] limit;
  logic              ok;

  assign port_ok       = 32'(port_index_i) < NUM_PORTS;
  assign pin_ok        = 32'(pin_index_i) < PINS_PER_PORT;
  assign last_port_low = (32'(port_index_i) == NUM_PORTS - 1) &&
                         (32'(pin_index_i) < LAST_PORT_FIRST_PIN);

  always_comb begin
    act_ok = 1'b1;
    case (gpio_prb_action_e'(action_i))
      ACT_MODE:      limit = LIM_MODE;
      ACT_OTYPE:     limit = LIM_OTYPE;
      ACT_SPEED:     limit = LIM_SPEED;
      ACT_PULL:      limit = LIM_PULL;
      ACT_READ_PIN:  limit = LIM_READ;
      ACT_LATCH_OP:  limit = LIM_LATCH_OP;
      ACT_SET_RESET: limit = LIM_SET_RESET;
      default: begin
        limit  = '0;
        act_ok = 1'b0;
      end
    endcase
  end

  assign ok = port_ok && pin_ok && !last_port_low && act_ok && (setting_value_i <= limit);

  always_comb begin
    ctrl_o          = '0;
    ctrl_o.ok       = ok;
    ctrl_o.wr_mode  = ok && (action_i == ACT_MODE);
    ctrl_o.wr_otype = ok && (action_i == ACT_OTYPE);
    ctrl_o.wr_speed = ok && (action_i == ACT_SPEED);
    ctrl_o.wr_pull  = ok && (action_i == ACT_PULL);
    ctrl_o.rd_pad   = ok && (action_i == ACT_READ_PIN);
    ctrl_o.wr_latch = ok && ((action_i == ACT_LATCH_OP) || (action_i == ACT_SET_RESET));
  end

endmodule : gpio_prb_decode

`default_nettype wire

FILE: hw/rtl/gpio_prb_port_bank.sv
// Per-port configuration registers and output latches, with the
// read-modify-write of one pin field per step. Depends on gpio_prb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gpio_prb_port_bank
  import gpio_prb_pkg::*;
#(
  parameter int unsigned NUM_PORTS     = 3,
  parameter int unsigned PINS_PER_PORT = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                step_i,
  input  wire gpio_prb_ctrl_t      ctrl_i,
  input  wire logic [PortW-1:0]    port_index_i,
  input  wire logic [PinW-1:0]     pin_index_i,
  input  wire logic [ValueW-1:0]   setting_value_i,
  output logic      [PadW-1:0]     latch_o
);

  localparam int unsigned FieldW = 2 * PINS_PER_PORT;

  logic [FieldW-1:0]        mode_q  [NUM_PORTS];
  logic [FieldW-1:0]        mode_d  [NUM_PORTS];
  logic [PINS_PER_PORT-1:0] otype_q [NUM_PORTS];
  logic [PINS_PER_PORT-1:0] otype_d [NUM_PORTS];
  logic [FieldW-1:0]        speed_q [NUM_PORTS];
  logic [FieldW-1:0]        speed_d [NUM_PORTS];
  logic [FieldW-1:0]        pull_q  [NUM_PORTS];
  logic [FieldW-1:0]        pull_d  [NUM_PORTS];
  logic [PINS_PER_PORT-1:0] latch_q [NUM_PORTS];
  logic [PINS_PER_PORT-1:0] latch_d [NUM_PORTS];

  logic [NUM_PORTS-1:0]     sel;
  logic [PadW-1:0]          pin_oh_full;
  logic [PINS_PER_PORT-1:0] pin_oh;

  assign pin_oh_full = PadW'(1) << pin_index_i[3:0];
  assign pin_oh      = pin_oh_full[PINS_PER_PORT-1:0];

  always_comb begin
    for (int p = 0; p < NUM_PORTS; p++) begin
      sel[p] = (32'(port_index_i) == p);
    end
  end

  always_comb begin
    for (int p = 0; p < NUM_PORTS; p++) begin
      mode_d[p]  = mode_q[p];
      otype_d[p] = otype_q[p];
      speed_d[p] = speed_q[p];
      pull_d[p]  = pull_q[p];
      latch_d[p] = latch_q[p];
      if (step_i && sel[p]) begin
        for (int i = 0; i < PINS_PER_PORT; i++) begin
          if (pin_oh[i]) begin
            if (ctrl_i.wr_mode)  mode_d[p][2*i +: 2]  = setting_value_i;
            if (ctrl_i.wr_speed) speed_d[p][2*i +: 2] = setting_value_i;
            if (ctrl_i.wr_pull)  pull_d[p][2*i +: 2]  = setting_value_i;
            if (ctrl_i.wr_otype) otype_d[p][i]        = setting_value_i[0];
          end
        end
        if (ctrl_i.wr_latch) begin
          case (gpio_prb_latch_e'(setting_value_i))
            LATCH_CLEAR:  latch_d[p] = latch_q[p] & ~pin_oh;
            LATCH_SET:    latch_d[p] = latch_q[p] | pin_oh;
            LATCH_TOGGLE: latch_d[p] = latch_q[p] ^ pin_oh;
            default:      latch_d[p] = latch_q[p];
          endcase
        end
      end
    end
  end

  // Latch after the step; zero when no port matches
  always_comb begin
    latch_o = '0;
    for (int p = 0; p < NUM_PORTS; p++) begin
      if (sel[p]) latch_o = latch_o | PadW'(latch_d[p]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < NUM_PORTS; p++) begin
        mode_q[p]  <= '0;
        otype_q[p] <= '0;
        speed_q[p] <= '0;
        pull_q[p]  <= '0;
        latch_q[p] <= '0;
      end
    end else begin
      for (int p = 0; p < NUM_PORTS; p++) begin
        mode_q[p]  <= mode_d[p];
        otype_q[p] <= otype_d[p];
        speed_q[p] <= speed_d[p];
        pull_q[p]  <= pull_d[p];
        latch_q[p] <= latch_d[p];
      end
    end
  end

  // At most one port addressed by a stepping word
  a_sel_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i |-> $onehot0(sel))
    else $error("more than one port selected");

  // Port 0's latch never moves without a step
  a_latch_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> (latch_q[0] == $past(latch_q[0])))
    else $error("port 0 latch changed without a step");

endmodule : gpio_prb_port_bank

`default_nettype wire

FILE: hw/rtl/gpio_port_register_block.sv
// Top level of the GPIO port register block: input register, decode,
// port bank and result register. Depends on gpio_prb_pkg, gpio_prb_decode, gpio_prb_port_bank.
`timescale 1ns / 1ps
`default_nettype none

//  Channel  | Dir | Handshake                     | Word
//  ---------+-----+-------------------------------+------------------------------------------
//  s_axis   | in  | s_axis_tvalid_i/tready_o      | action, port, pin, value, pad levels
//  m_axis   | out | m_axis_tvalid_o/tready_i      | status, pin level, output latch
//
//  One word in, one word out. Two register stages (input, result): a taken word
//  is held in the input stage, then moves to the result stage and shows on m_axis.
//  One word per cycle sustained while m_axis_tready_i stays high, set by the
//  read-modify-write of the port bank.
//  Reset (rst_ni low, asynchronous) empties both stages and clears all port
//  registers and latches.
//  A stalled result holds the result stage; the input stage still takes one
//  more word, after which s_axis_tready_o drops until the result is taken.

module gpio_port_register_block
  import gpio_prb_pkg::*;
#(
  parameter int unsigned NUM_PORTS           = 3,
  parameter int unsigned PINS_PER_PORT       = 16,
  parameter int unsigned LAST_PORT_FIRST_PIN = 13
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  // [2:0] action, [4:3] port_index, [9:5] pin_index, [11:10] setting_value,
  // [27:12] pad_levels, [31:28] zero
  input  wire logic [InDataW-1:0]  s_axis_tdata_i,
  output logic                     m_axis_tvalid_o,
  input  wire logic                m_axis_tready_i,
  // [0] status, [1] pin_level, [17:2] output_latch, [23:18] zero
  output logic [OutDataW-1:0]      m_axis_tdata_o
);

  // Input stage
  logic               in_valid_q;
  logic [ActionW-1:0] action_q;
  logic [PortW-1:0]   port_q;
  logic [PinW-1:0]    pin_q;
  logic [ValueW-1:0]  value_q;
  logic [PadW-1:0]    pads_q;

  // Result stage
  logic               out_valid_q;
  logic               status_q;
  logic               level_q;
  logic [PadW-1:0]    latch_q;

  logic               advance;
  logic               in_take;
  gpio_prb_ctrl_t     ctrl;
  logic [PadW-1:0]    latch_after;
  logic               level;

  // Word moves from input to result stage when result slot is free or draining
  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign in_take         = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      action_q <= s_axis_tdata_i[2:0];
      port_q   <= s_axis_tdata_i[4:3];
      pin_q    <= s_axis_tdata_i[9:5];
      value_q  <= s_axis_tdata_i[11:10];
      pads_q   <= s_axis_tdata_i[27:12];
    end
  end

  gpio_prb_decode #(
    .NUM_PORTS          (NUM_PORTS),
    .PINS_PER_PORT      (PINS_PER_PORT),
    .LAST_PORT_FIRST_PIN(LAST_PORT_FIRST_PIN)
  ) u_decode (
    .action_i       (action_q),
    .port_index_i   (port_q),
    .pin_index_i    (pin_q),
    .setting_value_i(value_q),
    .ctrl_o         (ctrl)
  );

  gpio_prb_port_bank #(
    .NUM_PORTS    (NUM_PORTS),
    .PINS_PER_PORT(PINS_PER_PORT)
  ) u_port_bank (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (advance),
    .ctrl_i         (ctrl),
    .port_index_i   (port_q),
    .pin_index_i    (pin_q),
    .setting_value_i(value_q),
    .latch_o        (latch_after)
  );

  assign level = ctrl.rd_pad & pads_q[pin_q[3:0]];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      status_q <= !ctrl.ok;
      level_q  <= level;
      latch_q  <= latch_after;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'b0, latch_q, level_q, status_q};

  // A waiting input word is never dropped
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q)
    else $error("input word lost while stalled");

  // Every word moved on shows up as a result
  a_out_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("result stage empty after advance");

  // A rejected word never reports a pad level
  a_reject_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && status_q |-> !level_q)
    else $error("pin level set on rejected word");

  // Both stages full and output stalled: no more words taken
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && out_valid_q && !m_axis_tready_i |-> !s_axis_tready_o)
    else $error("ready high with both stages full");

endmodule : gpio_port_register_block

`default_nettype wire
